>>> rtl/core/blp_pkg.sv
// Shared types, constants and fixed-point helpers for the binomial lattice pricer.
`timescale 1ns / 1ps
`default_nettype none

package blp_pkg;

  localparam int PRICE_W   = 32;
  localparam int FACT_W    = 32;
  localparam int STEPS_W   = 9;
  localparam int FRAC_W    = 30;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_WEIGHT = 3'd4;

  localparam logic [STEPS_W-1:0] STEPS_RST  = 9'd1;
  localparam logic [FACT_W-1:0]  ONE_Q30    = 32'h4000_0000;
  localparam logic [FACT_W-1:0]  HALF_Q30   = 32'h2000_0000;
  localparam logic [PRICE_W-1:0] PRICE_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [PRICE_W-1:0] spot;
    logic [PRICE_W-1:0] strike;
  } req_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic               sat;
    logic [PRICE_W-1:0] val;
  } qres_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    logic load;
    logic done;
    logic sat;
  } lg_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAVES,
    ST_INDUCT,
    ST_FIN
  } top_state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_DOWN,
    LG_LEAF
  } lg_state_t;

  // Q16.16 times Q2.30, truncated, clamped at full scale
  function automatic qres_t qmul(input logic [PRICE_W-1:0] a, input logic [FACT_W-1:0] b);
    logic [PRICE_W+FACT_W-1:0] p;
    logic [PRICE_W+FACT_W-FRAC_W-1:0] sh;
    qres_t r;
    p  = {{FACT_W{1'b0}}, a} * {{PRICE_W{1'b0}}, b};
    sh = p[PRICE_W+FACT_W-1:FRAC_W];
    if (|sh[PRICE_W+FACT_W-FRAC_W-1:PRICE_W]) begin
      r.sat = 1'b1;
      r.val = PRICE_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = sh[PRICE_W-1:0];
    end
    return r;
  endfunction

  function automatic qres_t sadd(input logic [PRICE_W-1:0] a, input logic [PRICE_W-1:0] b);
    logic [PRICE_W:0] s;
    qres_t r;
    s = {1'b0, a} + {1'b0, b};
    if (s[PRICE_W]) begin
      r.sat = 1'b1;
      r.val = PRICE_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[PRICE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] leaf,
                                                input logic [PRICE_W-1:0] strike);
    return (leaf > strike) ? (leaf - strike) : '0;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/blp_stream_if.sv
// Valid/ready stream interface carrying one request or result payload.
`timescale 1ns / 1ps
`default_nettype none

interface blp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

`default_nettype wire

>>> rtl/core/blp_leaf_gen.sv
// Leaf generator: walks spot down the lattice, then along the leaves, one multiply a cycle.
`timescale 1ns / 1ps
`default_nettype none

module blp_leaf_gen #(
  parameter int CNT_W = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [CNT_W-1:0]            n,
  input  wire logic [blp_pkg::PRICE_W-1:0] spot,
  input  wire logic [blp_pkg::PRICE_W-1:0] strike,
  input  wire logic [blp_pkg::FACT_W-1:0]  down_factor,
  input  wire logic [blp_pkg::FACT_W-1:0]  leaf_ratio,
  output blp_pkg::lg_status_t              status,
  output logic [CNT_W-1:0]                 leaf_idx,
  output logic [blp_pkg::PRICE_W-1:0]      leaf_val
);
  import blp_pkg::*;

  lg_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [PRICE_W-1:0] leaf_r, leaf_nxt;
  logic [PRICE_W-1:0] strike_r, strike_nxt;
  logic               sat_r, sat_nxt;
  qres_t              prod;
  logic               cnt_last;

  assign cnt_last = (cnt_r == n_r);

  always_comb begin
    prod = qmul(leaf_r, (state_r == LG_DOWN) ? down_factor : leaf_ratio);
  end

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    leaf_nxt   = leaf_r;
    strike_nxt = strike_r;
    sat_nxt    = sat_r;
    case (state_r)
      LG_IDLE: begin
        if (start) begin
          leaf_nxt   = spot;
          strike_nxt = strike;
          n_nxt      = n;
          cnt_nxt    = '0;
          sat_nxt    = 1'b0;
          state_nxt  = (n == '0) ? LG_LEAF : LG_DOWN;
        end
      end
      LG_DOWN: begin
        leaf_nxt = prod.val;
        sat_nxt  = sat_r | prod.sat;
        if ((cnt_r + CNT_W'(1)) == n_r) begin
          cnt_nxt   = '0;
          state_nxt = LG_LEAF;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      LG_LEAF: begin
        if (cnt_last) begin
          state_nxt = LG_IDLE;
        end else begin
          leaf_nxt = prod.val;
          sat_nxt  = sat_r | prod.sat;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = LG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    status.load = (state_r == LG_LEAF);
    status.done = (state_r == LG_LEAF) && cnt_last;
    status.sat  = sat_r;
    leaf_idx    = cnt_r;
    leaf_val    = payoff(leaf_r, strike_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LG_IDLE;
      sat_r   <= 1'b0;
      leaf_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sat_r   <= sat_nxt;
      leaf_r  <= leaf_nxt;
    end
    cnt_r    <= cnt_nxt;
    n_r      <= n_nxt;
    strike_r <= strike_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/blp_cell.sv
// One lattice node: loads its leaf, then folds in its upper neighbor once per level.
`timescale 1ns / 1ps
`default_nettype none

module blp_cell #(
  parameter int CNT_W = 9,
  parameter int INDEX = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire blp_pkg::cell_ctl_t          ctl,
  input  wire logic [CNT_W-1:0]            leaf_idx,
  input  wire logic [blp_pkg::PRICE_W-1:0] leaf_val,
  input  wire logic [CNT_W-1:0]            level,
  input  wire logic [blp_pkg::FACT_W-1:0]  up_weight,
  input  wire logic [blp_pkg::FACT_W-1:0]  down_weight,
  input  wire logic [blp_pkg::PRICE_W-1:0] upper_val,
  input  wire logic                        upper_sat,
  output logic [blp_pkg::PRICE_W-1:0]      node_val,
  output logic                             sat
);
  import blp_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [PRICE_W-1:0] val_r, val_nxt;
  logic               sat_r, sat_nxt;
  logic               active;
  qres_t              hi, lo, sum;

  assign active = ctl.step && (MY_IDX < level);

  always_comb begin
    hi  = qmul(upper_val, up_weight);
    lo  = qmul(val_r, down_weight);
    sum = sadd(hi.val, lo.val);
  end

  always_comb begin
    val_nxt = val_r;
    if (ctl.load && (leaf_idx == MY_IDX)) begin
      val_nxt = leaf_val;
    end else if (active) begin
      val_nxt = sum.val;
    end
  end

  // sticky flag ripples toward cell zero one cell a cycle
  always_comb begin
    if (ctl.clear) begin
      sat_nxt = 1'b0;
    end else begin
      sat_nxt = sat_r | upper_sat | (active & (hi.sat | lo.sat | sum.sat));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      sat_r <= sat_nxt;
    end
    val_r <= val_nxt;
  end

  assign node_val = val_r;
  assign sat      = sat_r;

endmodule

`default_nettype wire

>>> rtl/core/binomial_lattice_call_pricer.sv
// Top level: configuration, job sequencing and the row of lattice cells.
// With n = min(steps, MAX_STEPS): n down multiplies, n+1 leaf loads, then the induction
// levels (cells below the current level update in parallel, one level a cycle), then the post.
// One job runs at a time. The result register lets the next request in while the
// previous result waits. Synchronous active-low reset clears control state; the node
// store needs no clearing, every job writes each node it reads.
`timescale 1ns / 1ps
`default_nettype none

module binomial_lattice_call_pricer #(
  parameter int MAX_STEPS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  blp_stream_if.sink                          in_ch,
  blp_stream_if.source                        out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import blp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int CMP_W  = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;
  localparam int NCELLS = MAX_STEPS + 1;

  logic [STEPS_W-1:0] steps_r;
  logic [FACT_W-1:0]  down_factor_r, leaf_ratio_r, up_weight_r, down_weight_r;

  top_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt, n_in;
  logic [CNT_W-1:0]   lvl_r, lvl_nxt;
  res_t               res_r;
  logic               out_valid_r;

  logic               accept, post;
  cell_ctl_t          ctl;
  lg_status_t         lg_st;
  logic [CNT_W-1:0]   leaf_idx;
  logic [PRICE_W-1:0] leaf_val;

  logic [PRICE_W-1:0] node_w [NCELLS+1];
  logic               sat_w  [NCELLS+1];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r       <= STEPS_RST;
      down_factor_r <= ONE_Q30;
      leaf_ratio_r  <= ONE_Q30;
      up_weight_r   <= HALF_Q30;
      down_weight_r <= HALF_Q30;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEPS:       steps_r       <= cfg_wdata[STEPS_W-1:0];
        REG_DOWN_FACTOR: down_factor_r <= cfg_wdata[FACT_W-1:0];
        REG_LEAF_RATIO:  leaf_ratio_r  <= cfg_wdata[FACT_W-1:0];
        REG_UP_WEIGHT:   up_weight_r   <= cfg_wdata[FACT_W-1:0];
        REG_DOWN_WEIGHT: down_weight_r <= cfg_wdata[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_in = (CMP_W'(steps_r) > CMP_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                      : CNT_W'(steps_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    lvl_nxt   = lvl_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt     = n_in;
          state_nxt = ST_LEAVES;
        end
      end
      ST_LEAVES: begin
        if (lg_st.done) begin
          lvl_nxt   = n_r;
          state_nxt = (n_r == '0) ? ST_FIN : ST_INDUCT;
        end
      end
      ST_INDUCT: begin
        lvl_nxt = lvl_r - CNT_W'(1);
        if (lvl_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    accept      = (state_r == ST_IDLE) && in_ch.valid;
    post        = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
    ctl.clear   = accept;
    ctl.load    = lg_st.load;
    ctl.step    = (state_r == ST_INDUCT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    n_r   <= n_nxt;
    lvl_r <= lvl_nxt;
    if (post) begin
      res_r.price     <= node_w[0];
      res_r.saturated <= sat_w[0] | lg_st.sat;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  blp_leaf_gen #(
    .CNT_W (CNT_W)
  ) u_leaf_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .n           (n_in),
    .spot        (in_ch.data.spot),
    .strike      (in_ch.data.strike),
    .down_factor (down_factor_r),
    .leaf_ratio  (leaf_ratio_r),
    .status      (lg_st),
    .leaf_idx    (leaf_idx),
    .leaf_val    (leaf_val)
  );

  // the top cell has no upper neighbor
  assign node_w[NCELLS] = '0;
  assign sat_w[NCELLS]  = 1'b0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    blp_cell #(
      .CNT_W (CNT_W),
      .INDEX (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .leaf_idx    (leaf_idx),
      .leaf_val    (leaf_val),
      .level       (lvl_r),
      .up_weight   (up_weight_r),
      .down_weight (down_weight_r),
      .upper_val   (node_w[k+1]),
      .upper_sat   (sat_w[k+1]),
      .node_val    (node_w[k]),
      .sat         (sat_w[k])
    );
  end

endmodule

`default_nettype wire

>>> rtl/core/blp_checker.sv
// Port-level checks for the lattice pricer and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module blp_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire blp_pkg::res_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // one job at a time: the block is busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a job runs");

  // no result can appear the cycle after a request is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result posted too early");

endmodule

bind binomial_lattice_call_pricer blp_checker u_blp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

>>> tb/lattice_price_checker.sv
// Checker for the lattice pricer: mirrors the registers, predicts each price, compares results.
`timescale 1ns / 1ps

module lattice_price_checker #(
  parameter int MAX_STEPS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  blp_stream_if.mon                           req_mon,
  blp_stream_if.mon                           res_mon,
  input  wire logic                           cfg_we,
  input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  priced
);
  import blp_pkg::*;

  logic [STEPS_W-1:0] steps_q;
  logic [FACT_W-1:0]  down_q;
  logic [FACT_W-1:0]  ratio_q;
  logic [FACT_W-1:0]  upw_q;
  logic [FACT_W-1:0]  dnw_q;

  res_t expected_prices[$];
  res_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    priced      = 0;
    steps_q     = STEPS_RST;
    down_q      = ONE_Q30;
    ratio_q     = ONE_Q30;
    upw_q       = HALF_Q30;
    dnw_q       = HALF_Q30;
  end

  // Top bit of the return value flags a clamp.
  function automatic logic [PRICE_W:0] mul_q30(input logic [PRICE_W-1:0] a,
                                               input logic [FACT_W-1:0]  b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    prod = prod >> FRAC_W;
    if (prod[63:32] != 32'd0) return {1'b1, PRICE_MAX};
    return {1'b0, prod[31:0]};
  endfunction

  function automatic logic [PRICE_W:0] add_clamp(input logic [PRICE_W-1:0] a,
                                                 input logic [PRICE_W-1:0] b);
    logic [PRICE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[PRICE_W]) return {1'b1, PRICE_MAX};
    return s;
  endfunction

  function automatic logic [PRICE_W-1:0] call_value(input logic [PRICE_W-1:0] leaf,
                                                    input logic [PRICE_W-1:0] strike);
    if (leaf > strike) return leaf - strike;
    return '0;
  endfunction

  function automatic res_t price_call(input req_t r);
    logic [PRICE_W-1:0] node [0:MAX_STEPS];
    logic [PRICE_W-1:0] leaf;
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    logic [PRICE_W:0]   t;
    logic               clipped;
    int                 n;
    res_t               res;
    n = (steps_q > MAX_STEPS) ? MAX_STEPS : int'(steps_q);
    clipped = 1'b0;
    leaf = r.spot;
    for (int i = 0; i < n; i++) begin
      t = mul_q30(leaf, down_q);
      clipped |= t[PRICE_W];
      leaf = t[PRICE_W-1:0];
    end
    node[0] = call_value(leaf, r.strike);
    for (int j = 1; j <= n; j++) begin
      t = mul_q30(leaf, ratio_q);
      clipped |= t[PRICE_W];
      leaf = t[PRICE_W-1:0];
      node[j] = call_value(leaf, r.strike);
    end
    // fold one level per pass, lowest node first so node[j+1] is still the child
    for (int i = n; i > 0; i--) begin
      for (int j = 0; j < i; j++) begin
        t = mul_q30(node[j+1], upw_q);
        clipped |= t[PRICE_W];
        hi = t[PRICE_W-1:0];
        t = mul_q30(node[j], dnw_q);
        clipped |= t[PRICE_W];
        lo = t[PRICE_W-1:0];
        t = add_clamp(hi, lo);
        clipped |= t[PRICE_W];
        node[j] = t[PRICE_W-1:0];
      end
    end
    res.price     = node[0];
    res.saturated = clipped;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [PRICE_W-1:0] exp_val,
                                 input logic [PRICE_W-1:0] got_val);
    mismatches++;
    $display("MISMATCH at %0t: %s: expected %h, got %h", $time, what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      steps_q = STEPS_RST;
      down_q  = ONE_Q30;
      ratio_q = ONE_Q30;
      upw_q   = HALF_Q30;
      dnw_q   = HALF_Q30;
      expected_prices.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEPS:       steps_q = cfg_wdata[STEPS_W-1:0];
          REG_DOWN_FACTOR: down_q  = cfg_wdata;
          REG_LEAF_RATIO:  ratio_q = cfg_wdata;
          REG_UP_WEIGHT:   upw_q   = cfg_wdata;
          REG_DOWN_WEIGHT: dnw_q   = cfg_wdata;
          default: ;
        endcase
      end
      // retire before queueing so a same-edge request cannot cover a spurious result
      if (res_mon.valid && res_mon.ready) begin
        if (expected_prices.size() == 0) begin
          report_mismatch("result with no request pending", '0, res_mon.data.price);
        end else begin
          want = expected_prices.pop_front();
          priced++;
          if (res_mon.data.price !== want.price)
            report_mismatch("price", want.price, res_mon.data.price);
          if (res_mon.data.saturated !== want.saturated)
            report_mismatch("saturated", 32'(want.saturated), 32'(res_mon.data.saturated));
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_prices.push_back(price_call(req_mon.data));
    end
    outstanding = expected_prices.size();
  end

endmodule

>>> tb/tb_binomial_lattice_call_pricer.sv
// Stimulus and verdict for the binomial lattice call pricer, checked by lattice_price_checker.
`timescale 1ns / 1ps

module tb_binomial_lattice_call_pricer;
  import blp_pkg::*;

  localparam int MAX_STEPS        = 256;
  localparam int RANDOM_REQUESTS  = 750;
  localparam int HOLD_LEN         = 1500;
  localparam int QUIET_LIMIT      = 20000;
  localparam int TAIL_CYCLES      = 3 * MAX_STEPS + 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int err_count;
  int pending;
  int results_seen;
  int settings_used;
  int requests_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  blp_stream_if #(.payload_t(req_t)) req_if ();
  blp_stream_if #(.payload_t(res_t)) res_if ();

  binomial_lattice_call_pricer #(.MAX_STEPS(MAX_STEPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if.sink),
    .out_ch    (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lattice_price_checker #(.MAX_STEPS(MAX_STEPS)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_if.mon),
    .res_mon     (res_if.mon),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (err_count),
    .outstanding (pending),
    .priced      (results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] steps_word,
                               input logic [FACT_W-1:0] down, input logic [FACT_W-1:0] ratio,
                               input logic [FACT_W-1:0] upw, input logic [FACT_W-1:0] dnw);
    write_reg(REG_STEPS, steps_word);
    write_reg(REG_DOWN_FACTOR, down);
    write_reg(REG_LEAF_RATIO, ratio);
    write_reg(REG_UP_WEIGHT, upw);
    write_reg(REG_DOWN_WEIGHT, dnw);
    settings_used++;
  endtask

  task automatic send_request(input logic [PRICE_W-1:0] spot, input logic [PRICE_W-1:0] strike);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.data.spot   <= spot;
    req_if.data.strike <= strike;
    req_if.valid       <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
  endtask

  // Drop valid and hold until every outstanding price has come back.
  task automatic drain;
    @(negedge clk);
    req_if.valid <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [PRICE_W-1:0] pick_spot();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRICE_MAX;
      2, 3, 4: return $urandom;
      default: return $urandom_range(20 << 16, 300 << 16);
    endcase
  endfunction

  function automatic logic [PRICE_W-1:0] pick_strike(input logic [PRICE_W-1:0] spot);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRICE_MAX;
      2, 3:    return $urandom;
      4:       return spot;
      default: return spot + $urandom_range(0, 80 << 16) - (40 << 16);
    endcase
  endfunction

  function automatic logic [FACT_W-1:0] pick_factor(input logic [FACT_W-1:0] center,
                                                    input int spread_lo, input int spread_hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return center - spread_lo + $urandom_range(0, spread_lo + spread_hi);
    endcase
  endfunction

  // Mostly short lattices; now and then the full depth or a count past it.
  task automatic random_setting(output bit deep);
    int roll;
    logic [CFG_DATA_W-1:0] steps_word;
    roll = $urandom_range(0, 99);
    if (roll < 3)       steps_word = $urandom_range(MAX_STEPS + 1, 511);
    else if (roll < 6)  steps_word = MAX_STEPS;
    else if (roll < 12) steps_word = 0;
    else                steps_word = $urandom_range(1, 12);
    deep = (steps_word > 32);
    steps_word = steps_word | ($urandom & 32'hFFFF_FE00);
    apply_setting(steps_word,
                  pick_factor(ONE_Q30, 1 << 26, 0),
                  pick_factor(ONE_Q30, 0, 1 << 27),
                  pick_factor(HALF_Q30, 1 << 25, 1 << 25),
                  pick_factor(HALF_Q30, 1 << 25, 1 << 25));
  endtask

  initial begin
    bit deep;
    bit hold_done;
    int burst;
    logic [PRICE_W-1:0] spot;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    res_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    settings_used  = 1;
    requests_sent  = 0;
    hold_done      = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: one step, unit factors, half weights.
    send_request('0, '0);
    send_request(PRICE_MAX, '0);
    send_request(PRICE_MAX, PRICE_MAX);
    send_request('0, PRICE_MAX);
    send_request(100 << 16, 90 << 16);
    drain();

    // Zero steps via a masked write: price is the payoff of spot itself.
    apply_setting(32'h0000_0200, ONE_Q30 - 32'd20_000_000, ONE_Q30 + 32'd42_000_000,
                  HALF_Q30, HALF_Q30 - 32'd300_000);
    send_request(100 << 16, 90 << 16);
    send_request(90 << 16, 100 << 16);
    send_request(PRICE_MAX, '0);
    drain();

    apply_setting(32'hFFFF_FE04, ONE_Q30 - 32'd20_000_000, ONE_Q30 + 32'd42_000_000,
                  HALF_Q30 + 32'd1_000_000, HALF_Q30 - 32'd1_500_000);
    send_request(100 << 16, 100 << 16);
    send_request(100 << 16, 80 << 16);
    drain();

    // Writes to indexes past the list must leave the lattice alone.
    for (int k = REG_UNUSED_FIRST; k <= REG_UNUSED_LAST; k++)
      write_reg(k[CFG_IDX_W-1:0], $urandom);
    send_request(100 << 16, 95 << 16);
    drain();

    // Growth factors near 4.0 clamp the leaves.
    apply_setting(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, HALF_Q30, HALF_Q30);
    send_request(PRICE_MAX, '0);
    send_request(1 << 16, '0);
    drain();

    // Weights near 4.0 overflow products and node sums.
    apply_setting(32'd2, ONE_Q30, ONE_Q30, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, '0);
    send_request('0, '0);
    drain();

    apply_setting(32'd5, '0, '0, '0, '0);
    send_request(PRICE_MAX, '0);
    drain();

    // Step count past the maximum clamps to full depth.
    apply_setting(32'd511, ONE_Q30 - 32'd2_000_000, ONE_Q30 + 32'd4_000_000,
                  HALF_Q30, HALF_Q30 - 32'd50_000);
    send_request(100 << 16, 100 << 16);
    send_request(PRICE_MAX, 32'd1);
    drain();

    apply_setting(MAX_STEPS, ONE_Q30 - 32'd2_000_000, ONE_Q30 + 32'd4_000_000,
                  HALF_Q30 + 32'd30_000, HALF_Q30 - 32'd80_000);
    send_request(100 << 16, 100 << 16);
    drain();

    // Random phases: sender light / receiver heavy, then swapped, then no idling.
    while (requests_sent < RANDOM_REQUESTS + 19) begin
      if (requests_sent < 19 + RANDOM_REQUESTS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 54;
      end else if (requests_sent < 19 + 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting(deep);
      burst = deep ? 4 : $urandom_range(15, 30);
      for (int b = 0; b < burst; b++) begin
        // stall the receiver for a long stretch while requests keep coming
        if (!hold_done && !deep && b == 3) begin
          hold_requests++;
          hold_done = 1'b1;
        end
        spot = pick_spot();
        send_request(spot, pick_strike(spot));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d requests priced under %0d register settings", results_seen,
             settings_used);
    $display("  steps 0 to 511, clamped products and sums, long receiver hold-off");
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/blp_pkg.sv
rtl/core/blp_stream_if.sv
rtl/core/blp_leaf_gen.sv
rtl/core/blp_cell.sv
rtl/core/binomial_lattice_call_pricer.sv
rtl/core/blp_checker.sv
tb/lattice_price_checker.sv
tb/tb_binomial_lattice_call_pricer.sv
